// ===== rtl/hpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hazard pointer reclaimer package
// Shared request codes, status codes and sequencer state type.
// ----------------------------------------------------------------------------
package hpr_pkg;

   typedef enum logic [1:0] {
      MODE_SET    = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_RETIRE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   localparam logic CSR_THREADS = 1'b0;
   localparam logic CSR_HAZARDS = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_PUSH,
      ST_SCAN,
      ST_MARK,
      ST_POP,
      ST_POPCHK,
      ST_TEST,
      ST_REPUSH,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/hazard_pointer_reclaimer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hazard pointer reclaimer unit
// Set, clear and retire requests over per-thread hazard stacks and retire
// rings, with dirty marks kept per node handle.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake        Payload
// req      in         valid / stall    mode, thread, node
// rsp      out        valid / stall    freed_valid, freed_node, status
// csr      in         valid / ready    index, data
//
// A set or clear runs through the decode and done states before the next request
// can be taken. A retire steps through scan, mark, pop, popchk, test and repush
// once per ring pass, bounded by two passes per ring slot; the sequential pass
// through the single-port table memories sets this sequence.
// After every configuration write a clearing pass runs over all
// MAX_THREADS*MAX_THREADS*MAX_HAZARDS entries (256 by default) of the
// retire ring memory before requests are taken; after reset the pass covers
// NODE_COUNT entries (1024 by default) so that the dirty marks clear as well.
// A finished response waits in the output register while rsp_stall is high;
// one further request may run meanwhile and then holds in its last state.
module hazard_pointer_reclaimer_unit
   import hpr_pkg::*;
#(
   parameter int MAX_THREADS = 8,
   parameter int MAX_HAZARDS = 4,
   parameter int NODE_COUNT  = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_mode,
   input  wire  [2:0]  req_thread,
   input  wire  [9:0]  req_node,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_freed_valid,
   output logic [9:0]  rsp_freed_node,
   output logic [1:0]  rsp_status,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [3:0]  csr_data
);

   localparam int SLOTS = MAX_THREADS * MAX_HAZARDS;
   localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int RDEPTH = MAX_THREADS * SLOTS;
   localparam int RW = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int PW = CW + 2;
   localparam int HW = $clog2(MAX_HAZARDS + 1);
   localparam int XW = (NW > RW) ? NW : RW;

   // Memories.
   logic [9:0] haz_mem [SLOTS];
   logic [9:0] ring_mem [RDEPTH];
   logic       dirty_mem [NODE_COUNT];

   logic [HW-1:0] top_ff [MAX_THREADS];
   logic [SW-1:0] rnd_ff [MAX_THREADS];
   logic [SW-1:0] head_ff [MAX_THREADS];
   logic [CW-1:0] cnt_ff [MAX_THREADS];

   state_type state_ff, state_in;
   logic [3:0] thr_cfg_ff;
   logic [2:0] haz_cfg_ff;
   logic [XW-1:0] clr_ff;
   logic dirty_init_ff;
   logic [1:0] mode_ff;
   logic [TW-1:0] t_ff;
   logic [9:0] node_ff;
   logic [TW:0] nt;
   logic [HW-1:0] nh;
   logic [CW-1:0] cap_ff;
   logic [PW-1:0] pass_ff;
   logic [9:0] got_ff;
   logic [9:0] haz_rd_ff, ring_rd_ff;
   logic dirty_rd_ff;
   logic rsp_valid_ff, fv_ff;
   logic [9:0] fn_ff;
   logic [1:0] st_ff;
   logic rsp_fv_ff;
   logic [9:0] rsp_fn_ff;
   logic [1:0] rsp_st_ff;
   logic thr_ok;
   logic [SW-1:0] cur_head, cur_rnd;
   logic [CW-1:0] cur_cnt;
   logic [HW-1:0] cur_top;
   logic [SW:0] tail_sum;
   logic [SW-1:0] tail_pos;
   logic [SW:0] head_next;
   logic [SW:0] rnd_next;
   logic [SW-1:0] haz_idx;
   logic [RW-1:0] ring_base;

   // Effective sizes.
   always_comb begin
      if (thr_cfg_ff == 4'd0) nt = (TW+1)'(1);
      else if (32'(thr_cfg_ff) > MAX_THREADS) nt = (TW+1)'(MAX_THREADS);
      else nt = (TW+1)'(thr_cfg_ff);
      if (haz_cfg_ff == 3'd0) nh = HW'(1);
      else if (32'(haz_cfg_ff) > MAX_HAZARDS) nh = HW'(MAX_HAZARDS);
      else nh = HW'(haz_cfg_ff);
   end

   assign cur_head = head_ff[t_ff];
   assign cur_rnd  = rnd_ff[t_ff];
   assign cur_cnt  = cnt_ff[t_ff];
   assign cur_top  = top_ff[t_ff];
   assign thr_ok   = (32'(t_ff) < 32'(nt));
   assign tail_sum = (SW+1)'(cur_head) + (SW+1)'(cur_cnt);
   assign tail_pos = (32'(tail_sum) >= 32'(cap_ff)) ? SW'(tail_sum - (SW+1)'(cap_ff))
                                                    : SW'(tail_sum);
   assign head_next = (SW+1)'(cur_head) + (SW+1)'(1);
   assign rnd_next  = (SW+1)'(cur_rnd) + (SW+1)'(1);
   assign haz_idx   = SW'(32'(t_ff) * 32'(nh) + 32'(cur_top));
   assign ring_base = RW'(32'(t_ff) * SLOTS);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (32'(clr_ff) >= RDEPTH - 1 && (!dirty_init_ff || 32'(clr_ff) >=
                        NODE_COUNT - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (csr_valid) state_in = ST_CLEAR;
                    else if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (!thr_ok || mode_ff == MODE_NONE) state_in = ST_DONE;
            else if (mode_ff == MODE_RETIRE) state_in = ST_PUSH;
            else state_in = ST_DONE;
         end
         ST_PUSH:   state_in = ST_SCAN;
         ST_SCAN:   state_in = (32'(pass_ff) >= 2 * 32'(cap_ff)) ? ST_DONE : ST_MARK;
         ST_MARK:   state_in = ST_POP;
         ST_POP:    state_in = ST_POPCHK;
         ST_POPCHK: state_in = (got_ff == 10'd0) ? ST_DONE : ST_TEST;
         ST_TEST:   state_in = dirty_rd_ff ? ST_REPUSH : ST_DONE;
         ST_REPUSH: state_in = ST_SCAN;
         // The result waits here while the output register is still held.
         ST_DONE:   state_in = (rsp_valid_ff && rsp_stall) ? ST_DONE : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall = !(state_ff == ST_IDLE && !csr_valid);
      csr_ready = (state_ff == ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_freed_valid = rsp_fv_ff;
      rsp_freed_node  = rsp_fn_ff;
      rsp_status      = rsp_st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         thr_cfg_ff <= 4'd8;
         haz_cfg_ff <= 3'd4;
         clr_ff <= '0;
         dirty_init_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_THREADS; i++) begin
            rnd_ff[i] <= '0; head_ff[i] <= '0; top_ff[i] <= '0; cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && !(rsp_valid_ff && rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         cap_ff <= CW'(32'(nt) * 32'(nh));
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + XW'(1);
               if (32'(clr_ff) < RDEPTH) ring_mem[RW'(clr_ff)] <= 10'd0;
               if (32'(clr_ff) < SLOTS) haz_mem[SW'(clr_ff)] <= 10'd0;
               if (dirty_init_ff && 32'(clr_ff) < NODE_COUNT) dirty_mem[NW'(clr_ff)] <= 1'b0;
               if (state_in == ST_IDLE) dirty_init_ff <= 1'b0;
               for (int i = 0; i < MAX_THREADS; i++) begin
                  rnd_ff[i] <= '0; head_ff[i] <= '0; top_ff[i] <= '0;
                  cnt_ff[i] <= CW'(32'(nt) * 32'(nh) - 1);
               end
            end
            ST_IDLE: begin
               clr_ff <= '0;
               if (csr_valid) begin
                  if (csr_index == CSR_THREADS) thr_cfg_ff <= csr_data;
                  else haz_cfg_ff <= csr_data[2:0];
               end else if (req_valid) begin
                  mode_ff <= req_mode;
                  t_ff <= TW'(req_thread);
                  node_ff <= req_node;
                  pass_ff <= '0;
                  fv_ff <= 1'b0; fn_ff <= 10'd0; st_ff <= STATUS_OK;
               end
            end
            ST_DECODE: begin
               if (thr_ok && mode_ff == MODE_SET) begin
                  if (32'(cur_top) >= 32'(nh)) st_ff <= STATUS_FULL;
                  else begin
                     haz_mem[haz_idx] <= node_ff;
                     top_ff[t_ff] <= cur_top + HW'(1);
                  end
               end else if (thr_ok && mode_ff == MODE_CLEAR) begin
                  if (cur_top == '0) st_ff <= STATUS_EMPTY;
                  else begin
                     top_ff[t_ff] <= cur_top - HW'(1);
                     haz_mem[SW'(32'(t_ff) * 32'(nh) + 32'(cur_top) - 1)] <= 10'd0;
                  end
               end
            end
            ST_PUSH: begin
               if (32'(cur_cnt) < 32'(cap_ff)) begin
                  ring_mem[ring_base + RW'(tail_pos)] <= node_ff;
                  cnt_ff[t_ff] <= cur_cnt + CW'(1);
               end
            end
            ST_SCAN: begin
               pass_ff <= pass_ff + PW'(1);
               haz_rd_ff <= haz_mem[cur_rnd];
               ring_rd_ff <= ring_mem[ring_base + RW'(cur_head)];
               rnd_ff[t_ff] <= (32'(rnd_next) >= 32'(cap_ff)) ? '0 : SW'(rnd_next);
            end
            ST_MARK: begin
               if (haz_rd_ff != 10'd0) dirty_mem[NW'(haz_rd_ff)] <= 1'b1;
            end
            ST_POP: begin
               if (cur_cnt == '0) got_ff <= 10'd0;
               else begin
                  got_ff <= ring_rd_ff;
                  head_ff[t_ff] <= (32'(head_next) >= 32'(cap_ff)) ? '0 : SW'(head_next);
                  cnt_ff[t_ff] <= cur_cnt - CW'(1);
               end
            end
            ST_POPCHK: dirty_rd_ff <= dirty_mem[NW'(got_ff)];
            ST_TEST: begin
               if (!dirty_rd_ff) begin
                  fv_ff <= 1'b1; fn_ff <= got_ff;
               end else dirty_mem[NW'(got_ff)] <= 1'b0;
            end
            ST_REPUSH: begin
               if (32'(cur_cnt) < 32'(cap_ff)) begin
                  ring_mem[ring_base + RW'(tail_pos)] <= got_ff;
                  cnt_ff[t_ff] <= cur_cnt + CW'(1);
               end
            end
            ST_DONE: begin
               if (!(rsp_valid_ff && rsp_stall)) begin
                  rsp_fv_ff <= fv_ff; rsp_fn_ff <= fn_ff; rsp_st_ff <= st_ff;
               end
            end
            default: ;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_freed_node))
      else $error("result changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("request taken while busy");
   a_free_nonnull: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_freed_valid |-> rsp_freed_node != 10'd0)
      else $error("null node released");

endmodule
`default_nettype wire
